// ===== design/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, constants and helpers for the pixel background subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

    localparam int PBS_PIXEL_COUNT = 524288;

    localparam int GRAY_W   = 8;
    localparam int CNT_W    = 8;
    localparam int RATE_W   = 9;
    localparam int IDX_W    = 19;
    localparam int CMD_W    = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Full-weight learn rate (1.0 in Q8)
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(256);

    localparam logic [GRAY_W-1:0] CHANGE_TH_RST = GRAY_W'(40);
    localparam logic [CNT_W-1:0]  HOLD_RST      = CNT_W'(30);
    localparam logic [RATE_W-1:0] RATE_RST      = RATE_W'(20);
    localparam logic [GRAY_W-1:0] FG_TH_RST     = GRAY_W'(40);

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CHANGE_TH = 2'd0,
        REG_HOLD      = 2'd1,
        REG_RATE      = 2'd2,
        REG_FG_TH     = 2'd3
    } pbs_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIRST  = 2'd0,
        CMD_WARMUP = 2'd1,
        CMD_NORMAL = 2'd2
    } pbs_cmd_t;

    typedef struct packed {
        logic [GRAY_W-1:0] change_th;
        logic [CNT_W-1:0]  hold;
        logic [RATE_W-1:0] rate;
        logic [GRAY_W-1:0] fg_th;
    } pbs_cfg_t;

    // One stored entry per pixel
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [GRAY_W-1:0] bg;
    } pbs_entry_t;

    function automatic logic [GRAY_W-1:0] absdiff8(input logic [GRAY_W-1:0] a,
                                                   input logic [GRAY_W-1:0] b);
        logic [GRAY_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/pbs_stream_if.sv =====
// ----------------------------------------------------------------------------
// pbs stream interfaces
// Valid/ready channels for pixel items in and result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbs_pix_if;
    import pbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  pixel_index;
    logic [GRAY_W-1:0] current_gray;
    logic [GRAY_W-1:0] earlier_gray;

    modport source (output valid, cmd, pixel_index, current_gray, earlier_gray,
                    input ready);
    modport sink   (input valid, cmd, pixel_index, current_gray, earlier_gray,
                    output ready);
endinterface

interface pbs_res_if;
    import pbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              foreground;
    logic [GRAY_W-1:0] background_level;

    modport source (output valid, foreground, background_level, input ready);
    modport sink   (input valid, foreground, background_level, output ready);
endinterface

`default_nettype wire

// ===== design/pbs_pixel_pipe.sv =====
// ----------------------------------------------------------------------------
// pbs_pixel_pipe
// Per-pixel state memory with read, update, write-back and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_pixel_pipe
    import pbs_pkg::*;
#(
    parameter int PIXEL_COUNT = PBS_PIXEL_COUNT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pbs_cfg_t          cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  in_cmd,
    input  wire logic [IDX_W-1:0]  in_index,
    input  wire logic [GRAY_W-1:0] in_cur,
    input  wire logic [GRAY_W-1:0] in_early,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_fg,
    output logic [GRAY_W-1:0]      out_bg
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [CW-1:0] COUNT_C = CW'(PIXEL_COUNT);

    pbs_entry_t state_mem [PIXEL_COUNT];

    logic              in_fire;
    logic [CW-1:0]     idx_ext;
    logic [AW-1:0]     in_addr;
    logic              in_range;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              s1_range_reg;
    logic [GRAY_W-1:0] s1_cur_reg;
    logic [GRAY_W-1:0] s1_early_reg;
    pbs_entry_t        rd_data_reg;
    logic              fwd_reg;
    pbs_entry_t        fwd_data_reg;

    logic              s1_fire;
    logic              wr_en;
    pbs_entry_t        wr_data;
    pbs_entry_t        old_entry;

    logic              changed;
    logic [CNT_W-1:0]  cnt_upd;
    logic [RATE_W-1:0] rate_sat;
    logic signed [8:0]  diff_s;
    logic signed [9:0]  rate_s;
    logic signed [18:0] prod_s;
    logic signed [18:0] acc_s;
    logic [GRAY_W-1:0] blend;
    logic [GRAY_W-1:0] bg_upd;

    logic              res_fg;
    logic [GRAY_W-1:0] res_bg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_fg_reg;
    logic [GRAY_W-1:0] out_bg_reg;

    // ---------------- input side ----------------
    assign idx_ext  = CW'(in_index);
    assign in_addr  = idx_ext[AW-1:0];
    assign in_range = idx_ext < COUNT_C;
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_addr_reg  <= in_addr;
            s1_range_reg <= in_range;
            s1_cur_reg   <= in_cur;
            s1_early_reg <= in_early;
            // write landing on the same edge as this read: memory returns old data
            fwd_reg      <= wr_en && (s1_addr_reg == in_addr);
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------- state memory ----------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[s1_addr_reg] <= wr_data;
        end
        if (in_fire)
        begin
            rd_data_reg <= state_mem[in_addr];
        end
    end

    // ---------------- update ----------------
    assign old_entry = fwd_reg ? fwd_data_reg : rd_data_reg;

    assign changed  = absdiff8(s1_cur_reg, s1_early_reg) > cfg.change_th;
    assign rate_sat = (cfg.rate > RATE_ONE) ? RATE_ONE : cfg.rate;

    always_comb
    begin
        if (changed)
        begin
            cnt_upd = cfg.hold;
        end
        else if (old_entry.cnt != '0)
        begin
            cnt_upd = old_entry.cnt - CNT_W'(1);
        end
        else
        begin
            cnt_upd = '0;
        end
    end

    // old + ((cur - old) * r) >> 8, floor on the signed sum
    assign diff_s = $signed({1'b0, s1_cur_reg}) - $signed({1'b0, old_entry.bg});
    assign rate_s = $signed({1'b0, rate_sat});
    assign prod_s = 19'(diff_s) * 19'(rate_s);
    assign acc_s  = $signed({3'b000, old_entry.bg, 8'h00}) + prod_s;
    assign blend  = acc_s[15:8];
    assign bg_upd = (cnt_upd == '0) ? blend : old_entry.bg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = old_entry;
        res_fg  = 1'b0;
        res_bg  = old_entry.bg;
        if (!s1_range_reg)
        begin
            res_bg = '0;
        end
        else
        begin
            case (s1_cmd_reg)
                CMD_FIRST:
                begin
                    wr_en       = s1_fire;
                    wr_data.bg  = s1_cur_reg;
                    wr_data.cnt = '0;
                    res_bg      = s1_cur_reg;
                end
                CMD_NORMAL:
                begin
                    wr_en       = s1_fire;
                    wr_data.bg  = bg_upd;
                    wr_data.cnt = cnt_upd;
                    res_bg      = bg_upd;
                    res_fg      = absdiff8(s1_cur_reg, bg_upd) > cfg.fg_th;
                end
                default:
                begin
                    res_bg = old_entry.bg;
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    assign out_valid_next = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_fg_reg <= res_fg;
            out_bg_reg <= res_bg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_fg    = out_fg_reg;
    assign out_bg    = out_bg_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && wr_en && (s1_addr_reg == in_addr) |=> fwd_reg)
        else $error("same-entry write not forwarded");

    a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("update stage advanced without a result");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_range_reg |=> (!out_fg_reg && out_bg_reg == '0))
        else $error("out-of-range item gave nonzero result");

    a_first_frame_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_range_reg && s1_cmd_reg == CMD_FIRST
        |=> (!out_fg_reg && out_bg_reg == $past(s1_cur_reg)))
        else $error("first frame did not load background");
`endif

endmodule

`default_nettype wire

// ===== design/pixel_background_subtractor_top.sv =====
// ----------------------------------------------------------------------------
// pixel_background_subtractor_top
// Running-average background subtraction gated by frame differences.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the output is not stalled and returns
// one result item per accepted item, in order: the per-pixel entry (background
// and hold counter, PIXEL_COUNT x 16 bits in one memory) is read synchronously
// and then updated, written back and the result registered. Back-to-back items
// to the same pixel are forwarded from the write-back, so the rate stays at one
// item per cycle for any index pattern. Entries are not cleared after reset:
// send a first-frame item for a pixel before any warm-up or normal item for it.
// The user must write registers over the APB port only while no items are in
// flight; the block itself does not enforce this.
`default_nettype none

module pixel_background_subtractor_top
    import pbs_pkg::*;
#(
    parameter int PIXEL_COUNT = PBS_PIXEL_COUNT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    pbs_pix_if.sink                pix_in,
    pbs_res_if.source              res_out
);

    pbs_cfg_t cfg_reg;
    pbs_cfg_t cfg_next;
    logic     cfg_we;
    pbs_reg_t reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = pbs_reg_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_sel)
                REG_CHANGE_TH: cfg_next.change_th = pwdata[GRAY_W-1:0];
                REG_HOLD:      cfg_next.hold      = pwdata[CNT_W-1:0];
                REG_RATE:      cfg_next.rate      = pwdata[RATE_W-1:0];
                REG_FG_TH:     cfg_next.fg_th     = pwdata[GRAY_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_th <= CHANGE_TH_RST;
            cfg_reg.hold      <= HOLD_RST;
            cfg_reg.rate      <= RATE_RST;
            cfg_reg.fg_th     <= FG_TH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CHANGE_TH: prdata = APB_DW'(cfg_reg.change_th);
            REG_HOLD:      prdata = APB_DW'(cfg_reg.hold);
            REG_RATE:      prdata = APB_DW'(cfg_reg.rate);
            REG_FG_TH:     prdata = APB_DW'(cfg_reg.fg_th);
            default:       prdata = '0;
        endcase
    end

    pbs_pixel_pipe #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .in_cmd    (pix_in.cmd),
        .in_index  (pix_in.pixel_index),
        .in_cur    (pix_in.current_gray),
        .in_early  (pix_in.earlier_gray),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_fg    (res_out.foreground),
        .out_bg    (res_out.background_level)
    );

endmodule

`default_nettype wire
